// ----- rtl/urc_pkg.sv -----
package urc_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TRIG_PERIOD = 2'd0;
  localparam logic [1:0] REG_TRIG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ECHO_TMO    = 2'd2;
  localparam logic [1:0] REG_MIN_ECHO    = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_TRIG_PERIOD = 16'd5000;
  localparam logic [7:0]  RST_TRIG_WIDTH  = 8'd1;
  localparam logic [16:0] RST_TMO_LIMIT   = 17'd2500;  // 25 ms * 100 ticks
  localparam logic [7:0]  RST_MIN_ECHO    = 8'd5;

  localparam logic [6:0]  TICKS_PER_MS    = 7'd100;
  localparam logic [15:0] DIST_NO_ECHO    = 16'hFFFF;

  // (len*100+29)/58 == ((50*len+14)*M) >> 26 with M = ceil(2^26/29),
  // exact for 50*len+14 < 2^21. Folded into one constant multiply-add.
  localparam logic [26:0] MM_MULT  = 27'd115704950;  // 50*M
  localparam logic [43:0] MM_BIAS  = 44'd32397386;   // 14*M
  localparam int          MM_SHIFT = 26;

  // Echo lengths at or above this saturate to no-echo distance
  localparam logic [31:0] MM_SAT_LEN = 32'd38011;

  typedef logic [1:0] cmd_t;

endpackage

// ----- rtl/ultrasonic_ranger_controller.sv -----
// Ultrasonic ranger controller, one item per input transfer.
// Each input transfer is held in the input register; its result is then
//   formed by the state update and loaded into the result register.
// Throughput: one item per cycle unless out_tready stalls the result.
// Reset (rst_n low, synchronous): counters, flags and handshakes cleared,
//   configuration registers return to their defaults.
module ultrasonic_ranger_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] echo_level, [7:1] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] trigger_out, [16:1] distance_mm,
                                  // [17] ready_res, [23:18] zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] trig_period_r;
  logic [7:0]  trig_width_r;
  logic [16:0] tmo_limit_r;   // timeout already scaled to ticks
  logic [7:0]  min_echo_r;

  // Input register
  logic          in_vld_r;
  urc_pkg::cmd_t in_cmd_r;
  logic          in_echo_r;

  // Controller state
  logic [31:0] elapsed_r, elapsed_nxt;   // ticks since last echo start
  logic [15:0] idle_r, idle_nxt;
  logic [7:0]  pulse_r, pulse_nxt;
  logic        active_r, active_nxt;     // also the trigger level
  logic        waiting_r, waiting_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        ready_r, ready_nxt;

  // Result register
  logic        out_vld_r;
  logic [23:0] out_data_r;

  logic        advance;
  logic [31:0] elapsed_inc;
  logic [15:0] idle_inc;
  logic [7:0]  pulse_inc;
  logic [43:0] mm_prod;
  logic [15:0] mm_val;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_period_r <= urc_pkg::RST_TRIG_PERIOD;
      trig_width_r  <= urc_pkg::RST_TRIG_WIDTH;
      tmo_limit_r   <= urc_pkg::RST_TMO_LIMIT;
      min_echo_r    <= urc_pkg::RST_MIN_ECHO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        urc_pkg::REG_TRIG_PERIOD: trig_period_r <= cfg_data;
        urc_pkg::REG_TRIG_WIDTH:  trig_width_r  <= cfg_data[7:0];
        urc_pkg::REG_ECHO_TMO:    tmo_limit_r   <= 17'(cfg_data[9:0] * urc_pkg::TICKS_PER_MS);
        urc_pkg::REG_MIN_ECHO:    min_echo_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_echo_r <= in_tdata[0];
    end
  end

  // Pulse length to millimetres, one constant multiply
  assign mm_prod = 44'(elapsed_r[15:0] * urc_pkg::MM_MULT) + urc_pkg::MM_BIAS;
  assign mm_val  = mm_prod[urc_pkg::MM_SHIFT +: 16];

  assign elapsed_inc = elapsed_r + 32'd1;
  assign idle_inc    = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
  assign pulse_inc   = (pulse_r != 8'hFF) ? pulse_r + 8'd1 : pulse_r;

  // Next state for the item in the input register
  always_comb begin
    elapsed_nxt = elapsed_r;
    idle_nxt    = idle_r;
    pulse_nxt   = pulse_r;
    active_nxt  = active_r;
    waiting_nxt = waiting_r;
    dist_nxt    = dist_r;
    ready_nxt   = ready_r;
    case (in_cmd_r)
      urc_pkg::CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        idle_nxt    = idle_inc;
        if (!active_r) begin
          if (idle_inc >= trig_period_r) begin
            active_nxt = 1'b1;
            pulse_nxt  = 8'd0;
            idle_nxt   = 16'd0;
          end
        end else begin
          pulse_nxt = pulse_inc;
          if (pulse_inc >= trig_width_r) begin
            active_nxt = 1'b0;
          end
        end
        if (waiting_r && (elapsed_inc > {15'd0, tmo_limit_r})) begin
          waiting_nxt = 1'b0;
          dist_nxt    = urc_pkg::DIST_NO_ECHO;
          ready_nxt   = 1'b1;
        end
      end
      urc_pkg::CMD_EDGE: begin
        if (in_echo_r) begin
          elapsed_nxt = 32'd0;
          waiting_nxt = 1'b1;
        end else begin
          waiting_nxt = 1'b0;
          // short or empty echoes leave the stored result alone
          if ((elapsed_r != 32'd0) && (elapsed_r >= {24'd0, min_echo_r})) begin
            dist_nxt  = (elapsed_r >= urc_pkg::MM_SAT_LEN) ? urc_pkg::DIST_NO_ECHO : mm_val;
            ready_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= 32'd0;
      idle_r    <= 16'd0;
      pulse_r   <= 8'd0;
      active_r  <= 1'b0;
      waiting_r <= 1'b0;
      dist_r    <= 16'd0;
      ready_r   <= 1'b0;
    end else if (advance) begin
      elapsed_r <= elapsed_nxt;
      idle_r    <= idle_nxt;
      pulse_r   <= pulse_nxt;
      active_r  <= active_nxt;
      waiting_r <= waiting_nxt;
      dist_r    <= dist_nxt;
      // a read clears ready after reporting it
      ready_r   <= ready_nxt && (in_cmd_r != urc_pkg::CMD_READ);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, ready_nxt, dist_nxt, active_nxt};
    end
  end

  // Checks
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_cmd_r == urc_pkg::CMD_READ) |=> !ready_r)
    else $error("ready not cleared by read");

  a_rise_arms: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_cmd_r == urc_pkg::CMD_EDGE) && in_echo_r |=>
      waiting_r && (elapsed_r == 32'd0))
    else $error("rising echo edge did not arm timeout");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_cmd_r) && $stable(in_echo_r))
    else $error("input register lost a pending item");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r && (out_data_r[0] == active_r) && (out_data_r[16:1] == dist_r))
    else $error("result does not match updated state");

endmodule
